### sv/mdht_pkg.sv
// mdht_pkg: shared types, codes and defaults for the MAC-to-domain hash table.
// No dependencies; used by every module of the block except mdht_ram.
package mdht_pkg;

    localparam int NUM_BUCKETS_DEF = 64;
    localparam int WAYS_DEF        = 4;

    localparam int MAC_W  = 48;
    localparam int DOM_W  = 8;
    localparam int OCC_W  = 9;
    localparam int SLOT_W = MAC_W + DOM_W;

    // action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    // slot read offset select, relative to the slot index counter
    localparam logic [1:0] RD_PREV = 2'd0;
    localparam logic [1:0] RD_CUR  = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [MAC_W-1:0] mac_addr;
        logic [DOM_W-1:0] domain_id;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [DOM_W-1:0] found_domain;
        logic [1:0]       status;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    typedef struct packed {
        logic       load_req;
        logic       hash_mul;
        logic       hash_mod;
        logic       base_calc;
        logic       idx_load_fill;
        logic       idx_clear;
        logic       idx_inc;
        logic       idx_dec;
        logic       slot_rd;
        logic [1:0] rd_sel;
        logic       wr_shift;
        logic       wr_new;
        logic       fill_inc;
        logic       fill_dec;
        logic       clr_wr;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       cnt_clr;
        logic       res_set;
        logic       res_hit;
        logic [1:0] res_status;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       idx_zero;
        logic       scan_end;
        logic       rm_last;
        logic       match;
        logic       clr_last;
    } sts_t;

endpackage

### sv/mdht_ram.sv
// mdht_ram: generic simple dual-port RAM, one write and one read port,
// registered read data. No dependencies.
module mdht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/mdht_ctrl.sv
// mdht_ctrl: sequencing state machine of the hash table.
// Depends on mdht_pkg (cmd_t, sts_t, action and status codes).
module mdht_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  mdht_pkg::sts_t sts,
    output mdht_pkg::cmd_t cmd
);

    localparam logic [3:0] S_RST_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_MUL      = 4'd2;
    localparam logic [3:0] S_MOD      = 4'd3;
    localparam logic [3:0] S_BASE     = 4'd4;
    localparam logic [3:0] S_DISP     = 4'd5;
    localparam logic [3:0] S_INS_LOOP = 4'd6;
    localparam logic [3:0] S_INS_MV   = 4'd7;
    localparam logic [3:0] S_INS_WR   = 4'd8;
    localparam logic [3:0] S_SCAN     = 4'd9;
    localparam logic [3:0] S_CHK      = 4'd10;
    localparam logic [3:0] S_RM_LOOP  = 4'd11;
    localparam logic [3:0] S_RM_MV    = 4'd12;
    localparam logic [3:0] S_CLR      = 4'd13;
    localparam logic [3:0] S_DONE     = 4'd14;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RST_CLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_RST_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.hash_mul = 1'b1;
                state_next   = (sts.action == mdht_pkg::ACT_CLEAR) ? S_CLR : S_MOD;
            end
            S_MOD:
            begin
                cmd.hash_mod = 1'b1;
                state_next   = S_BASE;
            end
            S_BASE:
            begin
                cmd.base_calc = 1'b1;
                state_next    = S_DISP;
            end
            S_DISP:
            begin
                if (sts.action == mdht_pkg::ACT_INSERT)
                begin
                    if (sts.full)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = mdht_pkg::STAT_FULL;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cmd.idx_load_fill = 1'b1;
                        state_next        = S_INS_LOOP;
                    end
                end
                else
                begin
                    cmd.idx_clear = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_INS_LOOP:
            begin
                if (sts.idx_zero)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd.slot_rd = 1'b1;
                    cmd.rd_sel  = mdht_pkg::RD_PREV;
                    state_next  = S_INS_MV;
                end
            end
            S_INS_MV:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_dec  = 1'b1;
                state_next   = S_INS_LOOP;
            end
            S_INS_WR:
            begin
                cmd.wr_new     = 1'b1;
                cmd.fill_inc   = 1'b1;
                cmd.cnt_inc    = 1'b1;
                cmd.res_set    = 1'b1;
                cmd.res_status = mdht_pkg::STAT_OK;
                state_next     = S_DONE;
            end
            S_SCAN:
            begin
                if (sts.scan_end)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = mdht_pkg::STAT_NOT_FOUND;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.slot_rd = 1'b1;
                    cmd.rd_sel  = mdht_pkg::RD_CUR;
                    state_next  = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.match)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_hit    = 1'b1;
                    cmd.res_status = mdht_pkg::STAT_OK;
                    state_next     = (sts.action == mdht_pkg::ACT_REMOVE) ? S_RM_LOOP : S_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_SCAN;
                end
            end
            S_RM_LOOP:
            begin
                if (sts.rm_last)
                begin
                    cmd.fill_dec = 1'b1;
                    cmd.cnt_dec  = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.slot_rd = 1'b1;
                    cmd.rd_sel  = mdht_pkg::RD_NEXT;
                    state_next  = S_RM_MV;
                end
            end
            S_RM_MV:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_RM_LOOP;
            end
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.cnt_clr    = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = mdht_pkg::STAT_OK;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                // wait until the output register is free or being drained
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_RST_CLR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### sv/mdht_datapath.sv
// mdht_datapath: hash, slot and fill-count memories, counters and result registers.
// Depends on mdht_pkg and mdht_ram.
module mdht_datapath #(
    parameter int NUM_BUCKETS = mdht_pkg::NUM_BUCKETS_DEF,
    parameter int WAYS        = mdht_pkg::WAYS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mdht_pkg::req_t in_data,
    input  mdht_pkg::cmd_t cmd,
    output mdht_pkg::sts_t sts,
    output mdht_pkg::rsp_t out_data
);

    localparam int DEPTH = NUM_BUCKETS * WAYS;
    localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(WAYS + 1);
    localparam int XW    = AW + FW;
    localparam int SUM_W = 10;              // three bytes summed, at most 765
    localparam int SHIFT = 20;
    localparam int RW    = SHIFT + 1;
    localparam int PW    = SUM_W + RW;
    localparam int RMW   = SUM_W + 1;       // remainder estimate stays below 2*NUM_BUCKETS
    localparam int QNW   = 2 * SUM_W;
    localparam int RECIP = (1 << SHIFT) / NUM_BUCKETS;
    localparam int DW    = mdht_pkg::DOM_W;
    localparam int SW    = mdht_pkg::SLOT_W;
    localparam int OW    = mdht_pkg::OCC_W;

    localparam logic [RW-1:0]  RECIP_C = RW'(RECIP);
    localparam logic [RMW-1:0] NB_C    = RMW'(NUM_BUCKETS);
    localparam logic [QNW-1:0] NB_Q    = QNW'(NUM_BUCKETS);
    localparam logic [FW-1:0]  WAYS_C  = FW'(WAYS);
    localparam logic [AW-1:0]  WAYS_A  = AW'(WAYS);
    localparam logic [BW-1:0]  LAST_B  = BW'(NUM_BUCKETS - 1);

    mdht_pkg::req_t req_reg;
    mdht_pkg::rsp_t rsp_reg;
    logic [SUM_W-1:0] q_reg;
    logic [BW-1:0]    bucket_reg;
    logic [AW-1:0]    base_reg;
    logic [FW-1:0]    idx_reg;
    logic [BW-1:0]    clr_idx_reg;
    logic [OW-1:0]    cnt_reg;
    logic             res_hit_reg;
    logic [DW-1:0]    res_dom_reg;
    logic [1:0]       res_status_reg;

    logic [SUM_W-1:0] sum;
    logic [PW-1:0]    prod;
    logic [QNW-1:0]   qn;
    logic [RMW-1:0]   rem_est;
    logic [RMW-1:0]   rem_fix;
    logic [FW-1:0]    rd_off;
    logic [FW-1:0]    wr_off;
    logic [XW-1:0]    rd_sum;
    logic [XW-1:0]    wr_sum;
    logic [FW:0]      idx_plus;

    logic [SW-1:0]    slot_rd_data;
    logic [SW-1:0]    slot_wr_data;
    logic             slot_wr_en;
    logic [FW-1:0]    fill_q;
    logic [FW-1:0]    fill_wr_data;
    logic [BW-1:0]    fill_wr_addr;
    logic             fill_wr_en;

    // bucket hash: bytes 3..5 summed, reduced by reciprocal multiply and one fix-up
    assign sum     = {2'b00, req_reg.mac_addr[23:16]} + {2'b00, req_reg.mac_addr[15:8]}
                   + {2'b00, req_reg.mac_addr[7:0]};
    assign prod    = PW'(sum) * PW'(RECIP_C);
    assign qn      = QNW'(q_reg) * NB_Q;
    assign rem_est = RMW'(sum) - qn[RMW-1:0];
    assign rem_fix = (rem_est >= NB_C) ? (rem_est - NB_C) : rem_est;

    always_comb
    begin
        case (cmd.rd_sel)
            mdht_pkg::RD_PREV: rd_off = idx_reg - FW'(1);
            mdht_pkg::RD_NEXT: rd_off = idx_reg + FW'(1);
            default:           rd_off = idx_reg;
        endcase
    end

    assign wr_off = cmd.wr_new ? '0 : idx_reg;
    assign rd_sum = {{FW{1'b0}}, base_reg} + {{AW{1'b0}}, rd_off};
    assign wr_sum = {{FW{1'b0}}, base_reg} + {{AW{1'b0}}, wr_off};

    assign slot_wr_en   = cmd.wr_shift | cmd.wr_new;
    assign slot_wr_data = cmd.wr_new ? {req_reg.mac_addr, req_reg.domain_id} : slot_rd_data;

    mdht_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_wr_en),
        .wr_addr (wr_sum[AW-1:0]),
        .wr_data (slot_wr_data),
        .rd_en   (cmd.slot_rd),
        .rd_addr (rd_sum[AW-1:0]),
        .rd_data (slot_rd_data)
    );

    assign fill_wr_en   = cmd.fill_inc | cmd.fill_dec | cmd.clr_wr;
    assign fill_wr_addr = cmd.clr_wr ? clr_idx_reg : bucket_reg;

    always_comb
    begin
        if (cmd.fill_inc)
        begin
            fill_wr_data = fill_q + FW'(1);
        end
        else if (cmd.fill_dec)
        begin
            fill_wr_data = fill_q - FW'(1);
        end
        else
        begin
            fill_wr_data = '0;
        end
    end

    mdht_ram #(
        .WIDTH (FW),
        .DEPTH (NUM_BUCKETS)
    ) u_fill_ram (
        .clk     (clk),
        .wr_en   (fill_wr_en),
        .wr_addr (fill_wr_addr),
        .wr_data (fill_wr_data),
        .rd_en   (cmd.base_calc),
        .rd_addr (bucket_reg),
        .rd_data (fill_q)
    );

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= in_data;
        end
        if (cmd.hash_mul)
        begin
            q_reg <= prod[SHIFT +: SUM_W];
        end
        if (cmd.hash_mod)
        begin
            bucket_reg <= rem_fix[BW-1:0];
        end
        if (cmd.base_calc)
        begin
            base_reg <= AW'(bucket_reg) * WAYS_A;
        end
        if (cmd.res_set)
        begin
            res_hit_reg    <= cmd.res_hit;
            res_dom_reg    <= cmd.res_hit ? slot_rd_data[DW-1:0] : '0;
            res_status_reg <= cmd.res_status;
        end
        if (cmd.out_load)
        begin
            rsp_reg.hit          <= res_hit_reg;
            rsp_reg.found_domain <= res_dom_reg;
            rsp_reg.status       <= res_status_reg;
            rsp_reg.occupancy    <= cnt_reg;
        end
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            clr_idx_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.idx_load_fill)
            begin
                idx_reg <= fill_q;
            end
            else if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + FW'(1);
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_reg - FW'(1);
            end

            if (cmd.clr_wr)
            begin
                clr_idx_reg <= (clr_idx_reg == LAST_B) ? '0 : clr_idx_reg + BW'(1);
            end

            // count wraps at 9 bits, matching the reported occupancy
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + OW'(1);
            end
            else if (cmd.cnt_dec)
            begin
                cnt_reg <= cnt_reg - OW'(1);
            end
        end
    end

    assign idx_plus = {1'b0, idx_reg} + (FW + 1)'(1);

    assign sts.action   = req_reg.action;
    assign sts.full     = (fill_q >= WAYS_C);
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.scan_end = (idx_reg >= fill_q);
    assign sts.rm_last  = (idx_plus >= {1'b0, fill_q});
    assign sts.match    = (slot_rd_data[SW-1:DW] == req_reg.mac_addr);
    assign sts.clr_last = (clr_idx_reg == LAST_B);

    assign out_data = rsp_reg;

endmodule

### sv/mac_to_domain_hash_table.sv
// mac_to_domain_hash_table: top level, controller plus datapath, with checks.
// Depends on mdht_pkg, mdht_ctrl, mdht_datapath (and mdht_ram below it).
//
// MAC-to-domain lookup table. Each transfer on the input channel carries an action
// (insert, lookup, remove, clear), a 48-bit MAC and a domain id; exactly one
// result transfer follows for each, in order, carrying hit, the matched domain,
// a status code and the table occupancy after the operation. Keys hash to a
// bucket by summing MAC bytes 3..5 modulo NUM_BUCKETS; each bucket holds up to
// WAYS entries kept front to back, newest first, in a slot RAM of
// NUM_BUCKETS*WAYS words, with a per-bucket fill count in a second RAM.
// One operation is in flight at a time. Lookup and remove scan the bucket from
// the front until a match or the end of the fill; remove then moves the later
// entries forward to close the gap. Insert moves each entry back one slot, then
// writes the new one at the front; a full-bucket insert ends without touching
// the slots. Each slot visited takes a read state and a compare or write-back
// state, since the slot RAM read is registered. Clear sweeps the fill RAM one
// bucket per cycle; after reset the same sweep runs with in_ready low.
// The result sits in an output register, so a new input is taken while the
// previous result waits for out_ready; that next operation then holds in its
// final state until the output register is free.
module mac_to_domain_hash_table #(
    parameter int NUM_BUCKETS = mdht_pkg::NUM_BUCKETS_DEF,
    parameter int WAYS        = mdht_pkg::WAYS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mdht_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output mdht_pkg::rsp_t out_data
);

    mdht_pkg::cmd_t cmd;
    mdht_pkg::sts_t sts;

    // sequencing: owns the handshake and the result valid flag
    mdht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // hashing, memories, counters and the result register
    mdht_datapath #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .WAYS        (WAYS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

    // result register is never overwritten while a result is still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || out_ready))
        else $error("result register overwritten while pending");

    // an insert never grows a bucket that is already full
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_inc |-> !sts.full)
        else $error("fill count incremented on a full bucket");

    // the block is busy in the cycle after it takes an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted on back-to-back cycles");

    // a hit is only recorded on a key match
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_set && cmd.res_hit) |-> sts.match)
        else $error("hit recorded without a key match");

endmodule
